// ----- hdl/hba_pkg.sv -----
// Shared types, constants and the divider step function for the HSV brightness adjust unit.
// Used by every module of the unit; depends on nothing else.
package hba_pkg;

	localparam int FRAC_BITS = 16;
	localparam int Q_W = FRAC_BITS + 1;
	localparam int DIV_STEPS_PER_STAGE = 4;
	localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

	localparam logic MODE_SHIFT = 1'b0;
	localparam logic MODE_HEADROOM = 1'b1;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	// Payload carried through the long-division stages.
	typedef struct packed {
		logic [7:0] v;
		logic [2:0] sector;
		logic grey;
		logic [7:0] mx;
		logic [7:0] delta;
		logic [7:0] rs;
		logic [7:0] rf;
		logic [Q_W-1:0] qs;
		logic [FRAC_BITS-1:0] qf;
	} div_t;

	// Restoring division, several quotient bits per call, for saturation
	// (remainder over max) and hue fraction (remainder over delta) side by side.
	function automatic div_t div_steps(div_t x);
		div_t y;
		logic [8:0] tr;
		y = x;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			tr = {y.rs, 1'b0};
			if (tr >= {1'b0, y.mx}) begin
				tr = tr - {1'b0, y.mx};
				y.qs = {y.qs[Q_W-2:0], 1'b1};
			end else begin
				y.qs = {y.qs[Q_W-2:0], 1'b0};
			end
			y.rs = tr[7:0];
			tr = {y.rf, 1'b0};
			if (tr >= {1'b0, y.delta}) begin
				tr = tr - {1'b0, y.delta};
				y.qf = {y.qf[FRAC_BITS-2:0], 1'b1};
			end else begin
				y.qf = {y.qf[FRAC_BITS-2:0], 1'b0};
			end
			y.rf = tr[7:0];
		end
		return y;
	endfunction

endpackage

// ----- hdl/hba_front.sv -----
// Front stage: max, min, adjusted value, hue sector and remainder, divider seed.
// Depends on hba_pkg.
module hba_front (
	input  logic clk,
	input  logic arst_n,
	input  logic adjust_mode,
	input  logic signed [8:0] value_offset,
	input  logic up_valid,
	output logic up_stall,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic dn_valid,
	input  logic dn_stall,
	output hba_pkg::div_t dn_data
);

	logic valid_s1;
	hba_pkg::div_t data_s1;
	hba_pkg::div_t nxt;
	logic adv;
	logic [7:0] mx, mn, delta;
	logic signed [10:0] off_x, mx_x, lim, vs;
	logic signed [8:0] diff;
	logic [2:0] base;
	logic q16;

	assign adv = !valid_s1 || !dn_stall;
	assign up_stall = !adv;

	always_comb begin
		mx = (red_in > green_in) ? red_in : green_in;
		mx = (mx > blue_in) ? mx : blue_in;
		mn = (red_in < green_in) ? red_in : green_in;
		mn = (mn < blue_in) ? mn : blue_in;
		delta = mx - mn;

		off_x = 11'(value_offset);
		mx_x = {3'b000, mx};
		lim = '0;
		if (adjust_mode == hba_pkg::MODE_SHIFT) begin
			vs = mx_x + off_x;
		end else if (off_x > 0) begin
			lim = 11'sd255 - off_x;
			vs = (mx_x > lim) ? lim : mx_x;
		end else begin
			lim = -off_x;
			vs = (mx_x < lim) ? lim : mx_x;
		end
		if (vs < 0) vs = '0;
		if (vs > 11'sd255) vs = 11'sd255;

		if (red_in == mx) begin
			base = 3'd0;
			diff = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
		end else if (green_in == mx) begin
			base = 3'd2;
			diff = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
		end else begin
			base = 3'd4;
			diff = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
		end

		nxt = '0;
		nxt.v = vs[7:0];
		nxt.grey = (delta == 8'd0);
		nxt.mx = mx;
		nxt.delta = delta;
		// A negative hue difference wraps into the sector below.
		if (diff < 0) begin
			nxt.sector = (base == 3'd0) ? 3'd5 : base - 3'd1;
			nxt.rf = delta + diff[7:0];
		end else if (diff[7:0] == delta) begin
			nxt.sector = base + 3'd1;
			nxt.rf = '0;
		end else begin
			nxt.sector = base;
			nxt.rf = diff[7:0];
		end
		// Integer bit of saturation is set only when min is zero.
		q16 = (delta >= mx);
		nxt.qs = hba_pkg::Q_W'(q16);
		nxt.rs = q16 ? 8'd0 : delta;
		nxt.qf = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data = data_s1;

endmodule

// ----- hdl/hba_divider.sv -----
// Four-stage restoring divider for saturation and hue fraction.
// Depends on hba_pkg.
module hba_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_stall,
	input  hba_pkg::div_t up_data,
	output logic dn_valid,
	input  logic dn_stall,
	output hba_pkg::div_t dn_data
);

	logic valid_s2, valid_s3, valid_s4, valid_s5;
	hba_pkg::div_t div_s2, div_s3, div_s4, div_s5;
	logic adv2, adv3, adv4, adv5;

	assign adv5 = !valid_s5 || !dn_stall;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign up_stall = !adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv2) valid_s2 <= up_valid;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && up_valid) div_s2 <= hba_pkg::div_steps(up_data);
		if (adv3 && valid_s2) div_s3 <= hba_pkg::div_steps(div_s2);
		if (adv4 && valid_s3) div_s4 <= hba_pkg::div_steps(div_s3);
		if (adv5 && valid_s4) div_s5 <= hba_pkg::div_steps(div_s4);
	end

	assign dn_valid = valid_s5;
	assign dn_data = div_s5;

endmodule

// ----- hdl/hba_back.sv -----
// Back stages: saturation-fraction products, then the channel scaling and sector select.
// Depends on hba_pkg.
module hba_back (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_stall,
	input  hba_pkg::div_t up_data,
	output logic dn_valid,
	input  logic dn_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);

	logic valid_s6, valid_s7;
	logic adv6, adv7;
	logic [7:0] v_s6;
	logic [2:0] sector_s6;
	logic grey_s6;
	logic [hba_pkg::Q_W-1:0] s_s6, sf_s6, oms_s6, omsf_s6, omsfi_s6;
	logic [7:0] red_s7, green_s7, blue_s7;

	logic [hba_pkg::FRAC_BITS+hba_pkg::Q_W-1:0] prod_sf;
	logic [2*hba_pkg::Q_W-1:0] prod_sfi;
	logic [hba_pkg::Q_W-1:0] ff_inv, sf, sfi;
	logic [hba_pkg::Q_W+7:0] prod_p, prod_q, prod_t;
	logic [7:0] p, q, t;
	logic [7:0] ro, go, bo;

	assign adv7 = !valid_s7 || !dn_stall;
	assign adv6 = !valid_s6 || adv7;
	assign up_stall = !adv6;

	always_comb begin
		ff_inv = hba_pkg::ONE - {1'b0, up_data.qf};
		prod_sf = up_data.qs * up_data.qf;
		prod_sfi = up_data.qs * ff_inv;
		sf = prod_sf[hba_pkg::FRAC_BITS +: hba_pkg::Q_W];
		sfi = prod_sfi[hba_pkg::FRAC_BITS +: hba_pkg::Q_W];
	end

	always_comb begin
		prod_p = v_s6 * oms_s6;
		prod_q = v_s6 * omsf_s6;
		prod_t = v_s6 * omsfi_s6;
		p = prod_p[hba_pkg::FRAC_BITS +: 8];
		q = prod_q[hba_pkg::FRAC_BITS +: 8];
		t = prod_t[hba_pkg::FRAC_BITS +: 8];
		case (sector_s6)
			3'd0: begin ro = v_s6; go = t; bo = p; end
			3'd1: begin ro = q; go = v_s6; bo = p; end
			3'd2: begin ro = p; go = v_s6; bo = t; end
			3'd3: begin ro = p; go = q; bo = v_s6; end
			3'd4: begin ro = t; go = p; bo = v_s6; end
			default: begin ro = v_s6; go = p; bo = q; end
		endcase
		if (grey_s6) begin
			ro = v_s6;
			go = v_s6;
			bo = v_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (adv6) valid_s6 <= up_valid;
			if (adv7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv6 && up_valid) begin
			v_s6 <= up_data.v;
			sector_s6 <= up_data.sector;
			grey_s6 <= up_data.grey;
			s_s6 <= up_data.qs;
			sf_s6 <= sf;
			oms_s6 <= hba_pkg::ONE - up_data.qs;
			omsf_s6 <= hba_pkg::ONE - sf;
			omsfi_s6 <= hba_pkg::ONE - sfi;
		end
		if (adv7 && valid_s6) begin
			red_s7 <= ro;
			green_s7 <= go;
			blue_s7 <= bo;
		end
	end

	assign dn_valid = valid_s7;
	assign red_out = red_s7;
	assign green_out = green_s7;
	assign blue_out = blue_s7;

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && !grey_s6 |-> sector_s6 <= 3'd5)
		else $error("hue sector out of range");

	a_sf_le_s: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && !grey_s6 |-> sf_s6 <= s_s6)
		else $error("saturation product exceeds saturation");

	a_s6_to_s7: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && adv7 |=> valid_s7)
		else $error("request lost between last two stages");

endmodule

// ----- hdl/hsv_brightness_adjust_unit.sv -----
// HSV brightness adjust unit: RGB to HSV, value offset, HSV back to RGB.
// Throughput is one pixel per cycle while the output is not stalled.
// The seven stages are front, four long-division stages (four quotient bits each), and two back stages.
// A stalled output holds only the stages that are full; bubbles fill behind it.
// Reset clears all valid bits and sets adjust_mode and value_offset to zero.
// Depends on hba_pkg, hba_front, hba_divider and hba_back.
module hsv_brightness_adjust_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [8:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);

	logic adjust_mode_q;
	logic signed [8:0] value_offset_q;
	logic fr_valid, fr_stall, dv_valid, dv_stall;
	hba_pkg::div_t fr_data, dv_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adjust_mode_q <= 1'b0;
			value_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hba_pkg::REG_MODE: adjust_mode_q <= cfg_data[0];
				hba_pkg::REG_OFFSET: value_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hba_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adjust_mode(adjust_mode_q),
		.value_offset(value_offset_q),
		.up_valid(in_valid),
		.up_stall(in_stall),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.dn_valid(fr_valid),
		.dn_stall(fr_stall),
		.dn_data(fr_data)
	);

	hba_divider u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(fr_valid),
		.up_stall(fr_stall),
		.up_data(fr_data),
		.dn_valid(dv_valid),
		.dn_stall(dv_stall),
		.dn_data(dv_data)
	);

	hba_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(dv_valid),
		.up_stall(dv_stall),
		.up_data(dv_data),
		.dn_valid(out_valid),
		.dn_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out)
	);

	a_front_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> fr_valid)
		else $error("accepted request missing from front stage");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && dv_stall |=> dv_valid)
		else $error("divider dropped a stalled request");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && fr_stall |=> fr_valid && $stable(fr_data))
		else $error("front stage changed a stalled request");

endmodule

// ----- sim/hba_checker.sv -----
// Checker for the HSV brightness adjust unit: watches the config, request and result channels,
// predicts each result from the accepted request and compares. Depends on hba_pkg.
module hba_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic cfg_index,
	input  logic [8:0] cfg_data,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [7:0] red_out,
	input  logic [7:0] green_out,
	input  logic [7:0] blue_out,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	pixel_t expected_pixels[$];
	logic mode_q;
	logic [8:0] offset_q;

	assign pending = expected_pixels.size();

	function automatic pixel_t adjust_pixel(pixel_t px, logic mode, logic [8:0] offset);
		longint o, r, g, b, mx, mn, delta, v, h6, sector, s, ff, sf, sfi, p, q, t;
		pixel_t res;
		o = $signed(offset);
		r = px.r;
		g = px.g;
		b = px.b;
		mx = r > g ? r : g;
		mx = mx > b ? mx : b;
		mn = r < g ? r : g;
		mn = mn < b ? mn : b;
		delta = mx - mn;
		v = mx;
		if (mode == hba_pkg::MODE_SHIFT) begin
			v = v + o;
		end else if (o > 0) begin
			if (v > 255 - o) v = 255 - o;
		end else begin
			if (v < -o) v = -o;
		end
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		if (delta == 0) begin
			res = '{v[7:0], v[7:0], v[7:0]};
			return res;
		end
		s = (delta << hba_pkg::FRAC_BITS) / mx;
		if (r >= mx) h6 = g - b;
		else if (g >= mx) h6 = 2 * delta + b - r;
		else h6 = 4 * delta + r - g;
		if (h6 < 0) h6 = h6 + 6 * delta;
		sector = h6 / delta;
		ff = ((h6 % delta) << hba_pkg::FRAC_BITS) / delta;
		if (sector >= 6) sector = 0;
		sf = (s * ff) >> hba_pkg::FRAC_BITS;
		sfi = (s * ((1 << hba_pkg::FRAC_BITS) - ff)) >> hba_pkg::FRAC_BITS;
		p = (v * ((1 << hba_pkg::FRAC_BITS) - s)) >> hba_pkg::FRAC_BITS;
		q = (v * ((1 << hba_pkg::FRAC_BITS) - sf)) >> hba_pkg::FRAC_BITS;
		t = (v * ((1 << hba_pkg::FRAC_BITS) - sfi)) >> hba_pkg::FRAC_BITS;
		case (sector)
			0: res = '{v[7:0], t[7:0], p[7:0]};
			1: res = '{q[7:0], v[7:0], p[7:0]};
			2: res = '{p[7:0], v[7:0], t[7:0]};
			3: res = '{p[7:0], q[7:0], v[7:0]};
			4: res = '{t[7:0], p[7:0], v[7:0]};
			default: res = '{v[7:0], p[7:0], q[7:0]};
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			mode_q <= hba_pkg::MODE_SHIFT;
			offset_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == hba_pkg::REG_MODE) mode_q <= cfg_data[0];
				else offset_q <= cfg_data;
			end
			if (in_valid && !in_stall)
				expected_pixels.push_back(adjust_pixel('{red_in, green_in, blue_in},
					mode_q, offset_q));
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (red_out != want.r) report_mismatch("red_out", red_out, want.r);
					if (green_out != want.g) report_mismatch("green_out", green_out, want.g);
					if (blue_out != want.b) report_mismatch("blue_out", blue_out, want.b);
				end
			end
		end
	end
endmodule

// ----- sim/tb_hsv_brightness_adjust_unit.sv -----
// Testbench top for the HSV brightness adjust unit: drives configuration and pixel requests,
// stalls the output at random, and gives the verdict. Depends on hba_pkg and hba_checker.
module tb_hsv_brightness_adjust_unit;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = hba_pkg::REG_MODE;
	logic [8:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] red_out, green_out, blue_out;
	int errors, pending;
	int cycles = 0;
	bit hold_off = 0;
	bit quiet = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	hsv_brightness_adjust_unit dut (.*);

	hba_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("hsv_brightness_adjust_unit test failed");
			$finish;
		end
	end

	// Output stall: random, except during the quiet stretch and the long hold-off.
	always @(posedge clk)
		out_stall <= hold_off || (!quiet && $urandom_range(99) < 10);

	task automatic write_reg(logic idx, logic [8:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while (!quiet && $urandom_range(99) < 10) begin
			in_valid <= 0;
			@(posedge clk);
		end
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_random(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: begin
					automatic logic [7:0] x = 8'($urandom);
					send_pixel(x, x, x);
				end
				default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
		end
	endtask

	initial begin
		logic [8:0] offsets[8];
		offsets = '{9'd0, 9'd255, -9'sd255, 9'h100, 9'd1, -9'sd1, 9'd100, -9'sd77};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, grey pixels and every hue sector.
		send_pixel(0, 0, 0);
		send_pixel(255, 255, 255);
		send_pixel(128, 128, 128);
		send_pixel(255, 0, 0);
		send_pixel(255, 255, 0);
		send_pixel(0, 255, 0);
		send_pixel(0, 255, 255);
		send_pixel(0, 0, 255);
		send_pixel(255, 0, 255);
		send_pixel(255, 0, 1);
		send_pixel(1, 0, 0);
		send_pixel(200, 100, 50);
		drain();
		for (int m = 0; m < 2; m++) begin
			for (int k = 0; k < 8; k++) begin
				write_reg(hba_pkg::REG_MODE, {8'd0, m[0]});
				write_reg(hba_pkg::REG_OFFSET, (k < 7) ? offsets[k] : 9'($urandom));
				if (k == 3) quiet = 1;
				send_pixel(255, 0, 0);
				send_pixel(0, 0, 0);
				send_pixel(255, 255, 255);
				send_random(110);
				quiet = 0;
				drain();
			end
		end
		// Receiver holds off while requests keep coming, so the pipeline fills.
		fork
			begin
				hold_off = 1;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			send_random(40);
		join
		drain();
		if (errors == 0) begin
			$display("hsv_brightness_adjust_unit test passed");
		end else begin
			$display("hsv_brightness_adjust_unit test failed");
		end
		$finish;
	end
endmodule
